/* design/gfpf_pkg.sv */
// Shared types and constants for the grid four-neighbour peak finder.
package gfpf_pkg;

	// Configuration port geometry
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 11;
	localparam int ROW_COUNT_W = 11;
	localparam int COL_COUNT_W = 7;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_COL_COUNT = 2'd1;

	// Depth of the queue between classifier and evaluator
	localparam int QUEUE_DEPTH = 2;

	// Candidate cells one item can settle, in emission order
	localparam int NUM_CAND   = 3;
	localparam int CAND_ABOVE = 0;
	localparam int CAND_LEFT  = 1;
	localparam int CAND_SELF  = 2;

	// Position class of one item, worked out at acceptance
	typedef struct packed {
		logic r_ge1;     // a row exists above
		logic r_ge2;     // two rows exist above
		logic last_row;
		logic last_col;
		logic has_left;  // a column exists to the left
		logic c_ge2;     // two columns exist to the left
		logic has_right; // a column exists to the right
	} cls_t;

endpackage

/* design/gfpf_ram.sv */
// Generic RAM: one write port, two registered read ports.
module gfpf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr_a,
	output logic [WIDTH-1:0] rd_data_a,
	input  logic [AW-1:0]    rd_addr_b,
	output logic [WIDTH-1:0] rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered reads; data holds while rd_en is low
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem_q[rd_addr_a];
			rd_data_b <= mem_q[rd_addr_b];
		end
	end

endmodule

/* design/gfpf_queue.sv */
// Short FIFO between the classifying front end and the evaluating back end.
module gfpf_queue #(
	parameter int WIDTH = 40
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] rd_data
);

	localparam int PTR_W = (gfpf_pkg::QUEUE_DEPTH > 1) ? $clog2(gfpf_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(gfpf_pkg::QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [gfpf_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(gfpf_pkg::QUEUE_DEPTH));
	assign valid   = (count_q != '0);
	assign rd_data = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(gfpf_pkg::QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(gfpf_pkg::QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

/* design/gfpf_front.sv */
// Front end: configuration registers, raster position counters, item classification.
module gfpf_front #(
	parameter int MAX_COLS    = 64,
	parameter int MAX_ROWS    = 1024,
	parameter int HEIGHT_BITS = 16,
	localparam int ROW_W = $clog2(MAX_ROWS),
	localparam int COL_W = $clog2(MAX_COLS)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gfpf_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [gfpf_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [HEIGHT_BITS-1:0]       in_height,
	input  logic                                q_full,
	output logic                                push,
	output logic signed [HEIGHT_BITS-1:0]       push_height,
	output logic [ROW_W-1:0]                    push_row,
	output logic [COL_W-1:0]                    push_col,
	output gfpf_pkg::cls_t                      push_cls
);

	// Compare widths wide enough for both the register and the limit
	localparam int RC_W = (ROW_W + 1 > gfpf_pkg::ROW_COUNT_W) ? ROW_W + 1 : gfpf_pkg::ROW_COUNT_W;
	localparam int CC_W = (COL_W + 1 > gfpf_pkg::COL_COUNT_W) ? COL_W + 1 : gfpf_pkg::COL_COUNT_W;

	logic [ROW_W-1:0] row_last_q;
	logic [COL_W-1:0] col_last_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;

	logic [RC_W-1:0]  row_req;
	logic [CC_W-1:0]  col_req;
	logic [ROW_W-1:0] row_last_new;
	logic [COL_W-1:0] col_last_new;
	logic             last_row;
	logic             last_col;

	assign cfg_ready = 1'b1;

	// Clamp a written count to its legal range and keep the last index
	assign row_req = RC_W'(cfg_data[gfpf_pkg::ROW_COUNT_W-1:0]);
	assign col_req = CC_W'(cfg_data[gfpf_pkg::COL_COUNT_W-1:0]);

	always_comb begin
		if (row_req < RC_W'(2)) begin
			row_last_new = ROW_W'(1);
		end else if (row_req > RC_W'(MAX_ROWS)) begin
			row_last_new = ROW_W'(MAX_ROWS - 1);
		end else begin
			row_last_new = ROW_W'(row_req - RC_W'(1));
		end
		if (col_req < CC_W'(2)) begin
			col_last_new = COL_W'(1);
		end else if (col_req > CC_W'(MAX_COLS)) begin
			col_last_new = COL_W'(MAX_COLS - 1);
		end else begin
			col_last_new = COL_W'(col_req - CC_W'(1));
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_last_q <= ROW_W'(1);
			col_last_q <= COL_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				gfpf_pkg::REG_ROW_COUNT: row_last_q <= row_last_new;
				gfpf_pkg::REG_COL_COUNT: col_last_q <= col_last_new;
				default: ;
			endcase
		end
	end

	// Classification of the item at the current position
	assign last_row = (row_q >= row_last_q);
	assign last_col = (col_q >= col_last_q);

	assign in_ready    = !q_full;
	assign push        = in_valid && !q_full;
	assign push_height = in_height;
	assign push_row    = row_q;
	assign push_col    = col_q;

	always_comb begin
		push_cls.r_ge1     = (row_q != '0);
		push_cls.r_ge2     = (row_q > ROW_W'(1));
		push_cls.last_row  = last_row;
		push_cls.last_col  = last_col;
		push_cls.has_left  = (col_q != '0);
		push_cls.c_ge2     = (col_q > COL_W'(1));
		push_cls.has_right = !last_col;
	end

	// Raster position counters, wrapping at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (push) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

endmodule

/* design/gfpf_back.sv */
// Back end: line store access, neighbour compares, result sequencing and output register.
module gfpf_back #(
	parameter int MAX_COLS    = 64,
	parameter int MAX_ROWS    = 1024,
	parameter int HEIGHT_BITS = 16,
	localparam int ROW_W = $clog2(MAX_ROWS),
	localparam int COL_W = $clog2(MAX_COLS)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	output logic                          q_pop,
	input  logic signed [HEIGHT_BITS-1:0] q_height,
	input  logic [ROW_W-1:0]              q_row,
	input  logic [COL_W-1:0]              q_col,
	input  gfpf_pkg::cls_t                q_cls,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ROW_W-1:0]              out_row,
	output logic [COL_W-1:0]              out_col,
	output logic                          out_last,
	output logic                          out_frame
);

	localparam int HB = HEIGHT_BITS;
	localparam int WW = 2 * HEIGHT_BITS;
	localparam int NC = gfpf_pkg::NUM_CAND;

	// Evaluation stage
	logic                   s_valid_s1;
	logic signed [HB-1:0]   h_s1;
	logic [ROW_W-1:0]       row_s1;
	logic [COL_W-1:0]       col_s1;
	gfpf_pkg::cls_t         cls_s1;
	logic [NC-1:0]          sent_s1;
	logic                   hit_a_s1;
	logic                   hit_b_s1;
	logic [WW-1:0]          byp_s1;

	// Values the previous items left in the two left columns
	logic signed [HB-1:0]   prev_h_q;
	logic signed [HB-1:0]   pp_h_q;
	logic signed [HB-1:0]   prev_old_q;

	// Output register
	logic                   out_valid_q;
	logic [ROW_W-1:0]       out_row_q;
	logic [COL_W-1:0]       out_col_q;
	logic                   out_last_q;
	logic                   out_frame_q;

	logic [COL_W-1:0]       rd_addr_a;
	logic [COL_W-1:0]       rd_addr_b;
	logic [WW-1:0]          rd_data_a;
	logic [WW-1:0]          rd_data_b;
	logic [WW-1:0]          word_a;
	logic [WW-1:0]          word_b;
	logic [WW-1:0]          wr_data;
	logic signed [HB-1:0]   n_old;
	logic signed [HB-1:0]   o_old;
	logic signed [HB-1:0]   n_right;
	logic [NC-1:0]          peaks;
	logic [NC-1:0]          remaining;
	logic [NC-1:0]          sel;
	logic [NC-1:0]          rest;
	logic                   out_free;
	logic                   emit;
	logic                   done;
	logic                   s_load;

	// Each word holds one column: older row in the upper half, newer row in the lower half
	gfpf_ram #(
		.WIDTH (WW),
		.DEPTH (MAX_COLS)
	) u_line_ram (
		.clk       (clk),
		.wr_en     (s_valid_s1),
		.wr_addr   (col_s1),
		.wr_data   (wr_data),
		.rd_en     (s_load),
		.rd_addr_a (rd_addr_a),
		.rd_data_a (rd_data_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_b (rd_data_b)
	);

	assign rd_addr_a = q_col;
	assign rd_addr_b = q_cls.has_right ? q_col + COL_W'(1) : q_col;

	// Forward a write that lands on the same edge as the read
	assign word_a  = hit_a_s1 ? byp_s1 : rd_data_a;
	assign word_b  = hit_b_s1 ? byp_s1 : rd_data_b;
	assign n_old   = word_a[HB-1:0];
	assign o_old   = word_a[WW-1:HB];
	assign n_right = word_b[HB-1:0];

	// Column shift: newer row moves up, the new height enters
	assign wr_data = {n_old, h_s1};

	// Peak tests; a neighbour only disqualifies when it exists and is strictly higher
	always_comb begin
		peaks = '0;
		peaks[gfpf_pkg::CAND_ABOVE] = cls_s1.r_ge1
			&& !(cls_s1.r_ge2 && (o_old > n_old))
			&& !(h_s1 > n_old)
			&& !(cls_s1.has_left && (prev_old_q > n_old))
			&& !(cls_s1.has_right && (n_right > n_old));
		peaks[gfpf_pkg::CAND_LEFT] = cls_s1.last_row && cls_s1.has_left
			&& !(cls_s1.r_ge1 && (prev_old_q > prev_h_q))
			&& !(cls_s1.c_ge2 && (pp_h_q > prev_h_q))
			&& !(h_s1 > prev_h_q);
		peaks[gfpf_pkg::CAND_SELF] = cls_s1.last_row && cls_s1.last_col
			&& !(cls_s1.r_ge1 && (n_old > h_s1))
			&& !(cls_s1.has_left && (prev_h_q > h_s1));
	end

	// Emit pending peaks one per cycle in settling order while the output register is free
	assign remaining = peaks & ~sent_s1;
	assign sel       = remaining & (~remaining + NC'(1));
	assign rest      = remaining & ~sel;
	assign out_free  = !out_valid_q || out_ready;
	assign emit      = s_valid_s1 && (remaining != '0) && out_free;
	assign done      = s_valid_s1 && ((remaining == '0) || (emit && (rest == '0)));
	assign s_load    = q_valid && (!s_valid_s1 || done);
	assign q_pop     = s_load;

	// Stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_valid_s1 <= 1'b0;
			sent_s1    <= '0;
			hit_a_s1   <= 1'b0;
			hit_b_s1   <= 1'b0;
		end else begin
			if (s_load) begin
				s_valid_s1 <= 1'b1;
				sent_s1    <= '0;
				hit_a_s1   <= s_valid_s1 && (col_s1 == rd_addr_a);
				hit_b_s1   <= s_valid_s1 && (col_s1 == rd_addr_b);
			end else begin
				if (done) begin
					s_valid_s1 <= 1'b0;
				end
				if (emit) begin
					sent_s1 <= sent_s1 | sel;
				end
			end
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (s_load) begin
			h_s1   <= q_height;
			row_s1 <= q_row;
			col_s1 <= q_col;
			cls_s1 <= q_cls;
			byp_s1 <= wr_data;
		end
	end

	// Left-column history, advanced when an item retires
	always_ff @(posedge clk) begin
		if (done) begin
			prev_h_q   <= h_s1;
			pp_h_q     <= prev_h_q;
			prev_old_q <= n_old;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_row_q   <= sel[gfpf_pkg::CAND_ABOVE] ? row_s1 - ROW_W'(1) : row_s1;
			out_col_q   <= sel[gfpf_pkg::CAND_LEFT] ? col_s1 - COL_W'(1) : col_s1;
			out_last_q  <= (rest == '0);
			out_frame_q <= cls_s1.last_row && cls_s1.last_col;
		end
	end

	assign out_valid = out_valid_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign out_last  = out_last_q;
	assign out_frame = out_frame_q;

endmodule

/* design/grid_four_neighbour_peak_finder.sv */
// Top level of the grid four-neighbour peak finder.
// Path: an input passes the queue, the evaluation stage and the output register.
// Throughput: one item per cycle unless output stalls; an item settling n peaks holds
// the evaluation stage, n at most 3, until the single output register has taken each.
// Reset: counters clear, row_count and col_count return to 2, all valids drop;
// the line store is not cleared; its contents are used only where they were written.
module grid_four_neighbour_peak_finder #(
	parameter int MAX_COLS    = 64,
	parameter int MAX_ROWS    = 1024,
	parameter int HEIGHT_BITS = 16,
	localparam int ROW_W = $clog2(MAX_ROWS),
	localparam int COL_W = $clog2(MAX_COLS),
	localparam int IN_W  = ((HEIGHT_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((ROW_W + COL_W + 7) / 8) * 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [IN_W-1:0]                  s_tdata,   // height
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [OUT_W-1:0]                 m_tdata,   // peak_row, peak_col
	output logic                             m_tlast,
	output logic                             m_tuser,   // frame_done
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [gfpf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [gfpf_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int CLS_W   = $bits(gfpf_pkg::cls_t);
	localparam int ENTRY_W = HEIGHT_BITS + ROW_W + COL_W + CLS_W;

	logic signed [HEIGHT_BITS-1:0] push_height;
	logic [ROW_W-1:0]              push_row;
	logic [COL_W-1:0]              push_col;
	gfpf_pkg::cls_t                push_cls;
	logic                          push;
	logic                          q_full;
	logic                          q_valid;
	logic                          q_pop;
	logic [ENTRY_W-1:0]            q_rd_data;
	logic signed [HEIGHT_BITS-1:0] q_height;
	logic [ROW_W-1:0]              q_row;
	logic [COL_W-1:0]              q_col;
	gfpf_pkg::cls_t                q_cls;
	logic [ROW_W-1:0]              peak_row;
	logic [COL_W-1:0]              peak_col;

	// Classifier
	gfpf_front #(
		.MAX_COLS    (MAX_COLS),
		.MAX_ROWS    (MAX_ROWS),
		.HEIGHT_BITS (HEIGHT_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_height   (s_tdata[HEIGHT_BITS-1:0]),
		.q_full      (q_full),
		.push        (push),
		.push_height (push_height),
		.push_row    (push_row),
		.push_col    (push_col),
		.push_cls    (push_cls)
	);

	// Queue between the two halves
	gfpf_queue #(
		.WIDTH (ENTRY_W)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data ({push_cls, push_col, push_row, push_height}),
		.full    (q_full),
		.pop     (q_pop),
		.valid   (q_valid),
		.rd_data (q_rd_data)
	);

	assign {q_cls, q_col, q_row, q_height} = q_rd_data;

	// Evaluator
	gfpf_back #(
		.MAX_COLS    (MAX_COLS),
		.MAX_ROWS    (MAX_ROWS),
		.HEIGHT_BITS (HEIGHT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_height  (q_height),
		.q_row     (q_row),
		.q_col     (q_col),
		.q_cls     (q_cls),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_row   (peak_row),
		.out_col   (peak_col),
		.out_last  (m_tlast),
		.out_frame (m_tuser)
	);

	assign m_tdata = OUT_W'({peak_col, peak_row});

	// A run that is not finished continues with its next result right away
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
		else $error("peak run broken before its last result");

	// All results of the frame's final pixel carry frame_done
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tuser && !m_tlast) |=> m_tuser)
		else $error("frame_done dropped inside the final run");

	// The evaluator never takes an entry from an empty queue
	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

endmodule
